FILE: src/dwsd_pkg.sv
// ----------------------------------------------------------------------------
// dwsd_pkg: shared types and constants for the dropout-weighted distance core
// Widths, command/status structs, multiplier operand codes and the logistic
// table contents, computed at elaboration.
// ----------------------------------------------------------------------------
package dwsd_pkg;

    localparam int COUNT_W     = 32;
    localparam int SUM_W       = 64;
    localparam int CFG_W       = 32;
    localparam int PADDR_W     = 3;
    localparam int SIG_W       = 17;
    localparam int SIG_ENTRIES = 2048;
    localparam int SIG_IDX_W   = $clog2(SIG_ENTRIES);
    localparam int MUL_W       = 34;
    localparam int Z_HI        = 36;    // bit weight of 16.0 in Q32.32

    localparam logic [SUM_W-1:0] ROUND_HALF = 64'd32768;

    // multiplier operand select
    localparam logic [1:0] MUL_ARG  = 2'd0;
    localparam logic [1:0] MUL_PROD = 2'd1;
    localparam logic [1:0] MUL_SQ   = 2'd2;

    typedef struct packed {
        logic                 load;
        logic                 mul_en;
        logic [1:0]           mul_sel;
        logic                 mag_en;
        logic                 acc;
        logic                 emit;
        logic                 fill_we;
        logic [SIG_IDX_W-1:0] fill_addr;
    } dwsd_cmd_t;

    typedef struct packed {
        logic last;
    } dwsd_stat_t;

    typedef logic [SIG_W-1:0] sig_table_t [SIG_ENTRIES];

    localparam logic [63:0]        LN2_Q32      = 64'd2977044472;
    localparam logic signed [63:0] SIXTEEN_Q32  = 64'sh0000_0010_0000_0000;
    localparam logic [63:0]        SIG_ZDIV     = 64'(2 * SIG_ENTRIES);
    localparam int                 TAYLOR_TERMS = 15;
    localparam int                 DIVQ_BITS    = 18;

    function automatic logic [63:0] div_by_term(input logic [63:0] x, input int n);
        logic [63:0] q;
        case (n)
            2:       q = x / 2;
            3:       q = x / 3;
            4:       q = x / 4;
            5:       q = x / 5;
            6:       q = x / 6;
            7:       q = x / 7;
            8:       q = x / 8;
            9:       q = x / 9;
            10:      q = x / 10;
            11:      q = x / 11;
            12:      q = x / 12;
            13:      q = x / 13;
            14:      q = x / 14;
            15:      q = x / 15;
            default: q = x;
        endcase
        return q;
    endfunction

    // e^-t, t in Q32.32, result in Q0.32
    function automatic logic [63:0] exp_neg_q32(input logic [63:0] t);
        logic [63:0]        k;
        logic [63:0]        r;
        logic [63:0]        term;
        logic [63:0]        res;
        logic signed [63:0] acc;
        k    = t / LN2_Q32;
        r    = t - k * LN2_Q32;
        term = 64'd1 << 32;
        acc  = $signed(term);
        for (int n = 1; n <= TAYLOR_TERMS; n++)
        begin
            term = div_by_term((term * r) >> 32, n);
            if ((n % 2) != 0)
                acc = acc - $signed(term);
            else
                acc = acc + $signed(term);
        end
        if (acc < 0)
            acc = 64'sd0;
        if (k > 64'd63)
            res = 64'd0;
        else
            res = 64'(acc) >> k;
        return res;
    endfunction

    // restoring division, quotient known to fit DIVQ_BITS
    function automatic logic [63:0] div_short_q(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] q;
        rem = num;
        q   = 64'd0;
        for (int b = DIVQ_BITS - 1; b >= 0; b--)
        begin
            if (rem >= (den << b))
            begin
                rem  = rem - (den << b);
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [SIG_W-1:0] sig_entry(input int i);
        logic signed [63:0] z;
        logic [63:0]        t;
        logic [63:0]        e;
        logic [63:0]        den;
        logic [63:0]        num;
        z   = $signed((64'(2 * i + 1) * (64'd32 << 32)) / SIG_ZDIV) - SIXTEEN_Q32;
        t   = (z < 0) ? 64'(-z) : 64'(z);
        e   = exp_neg_q32(t);
        den = (64'd1 << 32) + e;
        if (z >= 0)
            num = (e << 16) + (den >> 1);
        else
            num = (64'd1 << 48) + (den >> 1);
        return SIG_W'(div_short_q(num, den));
    endfunction

    function automatic sig_table_t build_sig_table();
        sig_table_t tbl;
        for (int i = 0; i < SIG_ENTRIES; i++)
        begin
            tbl[i] = sig_entry(i);
        end
        return tbl;
    endfunction

    localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

FILE: src/dwsd_if.sv
// ----------------------------------------------------------------------------
// dwsd_if: request and result channels
// Valid/ready channels carrying one element pair in and one distance out.
// ----------------------------------------------------------------------------
interface dwsd_in_if;
    logic                        valid;
    logic                        ready;
    logic [dwsd_pkg::COUNT_W-1:0] count_a;
    logic                        dropout_a;
    logic [dwsd_pkg::COUNT_W-1:0] count_b;
    logic                        dropout_b;
    logic                        last_element;

    modport source (
        output valid, count_a, dropout_a, count_b, dropout_b, last_element,
        input  ready
    );
    modport sink (
        input  valid, count_a, dropout_a, count_b, dropout_b, last_element,
        output ready
    );
endinterface

interface dwsd_out_if;
    logic                      valid;
    logic                      ready;
    logic [dwsd_pkg::SUM_W-1:0] distance;
    logic                      saturated;

    modport source (
        output valid, distance, saturated,
        input  ready
    );
    modport sink (
        input  valid, distance, saturated,
        output ready
    );
endinterface

FILE: src/dwsd_ram.sv
// ----------------------------------------------------------------------------
// dwsd_ram: generic single-port RAM
// One read/write address, registered read data.
// ----------------------------------------------------------------------------
module dwsd_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: src/dwsd_cfg.sv
// ----------------------------------------------------------------------------
// dwsd_cfg: APB register file
// Holds the logistic slope and midpoint.
// ----------------------------------------------------------------------------
module dwsd_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dwsd_pkg::PADDR_W-1:0] paddr,
    input  logic [dwsd_pkg::CFG_W-1:0]   pwdata,
    output logic [dwsd_pkg::CFG_W-1:0]   prdata,
    output logic                         pready,
    output logic [dwsd_pkg::CFG_W-1:0]   slope,
    output logic [dwsd_pkg::CFG_W-1:0]   midpoint
);

    localparam logic REG_SLOPE    = 1'b0;
    localparam logic REG_MIDPOINT = 1'b1;

    logic [dwsd_pkg::CFG_W-1:0] slope_reg;
    logic [dwsd_pkg::CFG_W-1:0] slope_next;
    logic [dwsd_pkg::CFG_W-1:0] midpoint_reg;
    logic [dwsd_pkg::CFG_W-1:0] midpoint_next;
    logic                       wr;
    logic                       sel;

    assign wr     = psel & penable & pwrite;
    assign sel    = paddr[2];
    assign pready = 1'b1;

    always_comb
    begin
        slope_next    = slope_reg;
        midpoint_next = midpoint_reg;
        if (wr)
        begin
            unique case (sel)
                REG_SLOPE:    slope_next    = pwdata;
                REG_MIDPOINT: midpoint_next = pwdata;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            REG_SLOPE:    prdata = slope_reg;
            REG_MIDPOINT: prdata = midpoint_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slope_reg    <= 32'd65536;
            midpoint_reg <= 32'd0;
        end
        else
        begin
            slope_reg    <= slope_next;
            midpoint_reg <= midpoint_next;
        end
    end

    assign slope    = slope_reg;
    assign midpoint = midpoint_reg;

endmodule

FILE: src/dwsd_ctrl.sv
// ----------------------------------------------------------------------------
// dwsd_ctrl: sequencer
// Table fill after reset, then one request at a time through the shared
// multiplier: argument, lookup, impute, difference, square, accumulate.
// ----------------------------------------------------------------------------
module dwsd_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   dropout_a,
    input  logic                   dropout_b,
    output logic                   in_ready,
    input  logic                   out_ready,
    output logic                   out_valid,
    input  dwsd_pkg::dwsd_stat_t   stat,
    output dwsd_pkg::dwsd_cmd_t    cmd
);

    localparam logic [2:0] ST_FILL = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_ARG  = 3'd2;
    localparam logic [2:0] ST_IDX  = 3'd3;
    localparam logic [2:0] ST_PROD = 3'd4;
    localparam logic [2:0] ST_DIFF = 3'd5;
    localparam logic [2:0] ST_SQ   = 3'd6;
    localparam logic [2:0] ST_ACC  = 3'd7;

    logic [2:0]                     state_reg;
    logic [2:0]                     state_next;
    logic [dwsd_pkg::SIG_IDX_W-1:0] fill_cnt_reg;
    logic [dwsd_pkg::SIG_IDX_W-1:0] fill_cnt_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic                           hold;

    assign hold = stat.last & out_valid_reg & ~out_ready;

    always_comb
    begin
        state_next     = state_reg;
        fill_cnt_next  = fill_cnt_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.mul_sel    = dwsd_pkg::MUL_ARG;
        cmd.fill_addr  = fill_cnt_reg;
        unique case (state_reg)
            ST_FILL:
            begin
                cmd.fill_we   = 1'b1;
                fill_cnt_next = fill_cnt_reg + 1'b1;
                if (fill_cnt_reg == dwsd_pkg::SIG_IDX_W'(dwsd_pkg::SIG_ENTRIES - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (dropout_a & dropout_b)
                        state_next = ST_ACC;
                    else if (dropout_a | dropout_b)
                        state_next = ST_ARG;
                    else
                        state_next = ST_SQ;
                end
            end
            ST_ARG:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = dwsd_pkg::MUL_ARG;
                state_next  = ST_IDX;
            end
            ST_IDX:
            begin
                state_next = ST_PROD;
            end
            ST_PROD:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = dwsd_pkg::MUL_PROD;
                state_next  = ST_DIFF;
            end
            ST_DIFF:
            begin
                cmd.mag_en = 1'b1;
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = dwsd_pkg::MUL_SQ;
                state_next  = ST_ACC;
            end
            ST_ACC:
            begin
                if (!hold)
                begin
                    cmd.acc    = 1'b1;
                    cmd.emit   = stat.last;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            fill_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_cnt_reg  <= fill_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: src/dwsd_dp.sv
// ----------------------------------------------------------------------------
// dwsd_dp: datapath
// Operand registers, shared multiply-add, logistic table, imputation,
// saturating accumulator and result register.
// ----------------------------------------------------------------------------
module dwsd_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dwsd_pkg::dwsd_cmd_t          cmd,
    output dwsd_pkg::dwsd_stat_t         stat,
    input  logic [dwsd_pkg::CFG_W-1:0]   slope,
    input  logic [dwsd_pkg::CFG_W-1:0]   midpoint,
    input  logic [dwsd_pkg::COUNT_W-1:0] count_a,
    input  logic                         dropout_a,
    input  logic [dwsd_pkg::COUNT_W-1:0] count_b,
    input  logic                         dropout_b,
    input  logic                         last_element,
    output logic [dwsd_pkg::SUM_W-1:0]   distance,
    output logic                         saturated
);

    localparam int CW = dwsd_pkg::COUNT_W;
    localparam int SW = dwsd_pkg::SUM_W;
    localparam int MW = dwsd_pkg::MUL_W;
    localparam int IW = dwsd_pkg::SIG_IDX_W;
    localparam int ZH = dwsd_pkg::Z_HI;
    localparam int XW = CW + 3;

    logic [CW-1:0]   c_reg;
    logic [CW-1:0]   other_reg;
    logic [CW:0]     dmid_reg;
    logic [CW:0]     dimp_reg;
    logic            last_reg;
    logic            skip_reg;
    logic [CW-1:0]   mag_reg;
    logic [CW-1:0]   mag_next;
    logic [SW-1:0]   mul_reg;
    logic [SW-1:0]   mul_next;
    logic [SW-1:0]   sum_reg;
    logic [SW-1:0]   sum_next;
    logic            ovf_reg;
    logic            ovf_next;
    logic [SW-1:0]   dist_out_reg;
    logic            sat_out_reg;

    logic [CW-1:0]   c_sel;
    logic [CW-1:0]   o_sel;
    logic [CW:0]     dab;
    logic [CW:0]     dab_abs;
    logic [MW-1:0]   mul_a;
    logic [MW-1:0]   mul_b;
    logic [SW-1:0]   mul_add;
    logic signed [2*MW-1:0] mul_full;
    logic            z_in_rng;
    logic [IW-1:0]   idx;
    logic [IW-1:0]   ram_addr;
    logic [dwsd_pkg::SIG_W-1:0] p;
    logic [XW-1:0]   cp;
    logic [XW-1:0]   dd;
    logic [XW-1:0]   dd_abs;
    logic [SW-1:0]   term;
    logic [SW:0]     sum_add;
    logic [SW-1:0]   sum_new;
    logic            ovf_new;

    // request capture
    assign c_sel   = dropout_a ? count_a : count_b;
    assign o_sel   = dropout_a ? count_b : count_a;
    assign dab     = {count_a[CW-1], count_a} - {count_b[CW-1], count_b};
    assign dab_abs = dab[CW] ? (~dab + 1'b1) : dab;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            c_reg     <= c_sel;
            other_reg <= o_sel;
            dmid_reg  <= {o_sel[CW-1], o_sel} - {midpoint[CW-1], midpoint};
            dimp_reg  <= {o_sel[CW-1], o_sel} - {c_sel[CW-1], c_sel};
            last_reg  <= last_element;
            skip_reg  <= dropout_a & dropout_b;
        end
        mag_reg <= mag_next;
        mul_reg <= mul_next;
        if (cmd.emit)
        begin
            dist_out_reg <= sum_new;
            sat_out_reg  <= ovf_new;
        end
    end

    // shared multiply-add
    always_comb
    begin
        case (cmd.mul_sel)
            dwsd_pkg::MUL_ARG:
            begin
                mul_a   = {{(MW-CW){slope[CW-1]}}, slope};
                mul_b   = {{(MW-CW-1){dmid_reg[CW]}}, dmid_reg};
                mul_add = '0;
            end
            dwsd_pkg::MUL_PROD:
            begin
                mul_a   = {{(MW-dwsd_pkg::SIG_W){1'b0}}, p};
                mul_b   = {{(MW-CW-1){dimp_reg[CW]}}, dimp_reg};
                mul_add = dwsd_pkg::ROUND_HALF;
            end
            dwsd_pkg::MUL_SQ:
            begin
                mul_a   = {{(MW-CW){1'b0}}, mag_reg};
                mul_b   = {{(MW-CW){1'b0}}, mag_reg};
                mul_add = dwsd_pkg::ROUND_HALF;
            end
            default:
            begin
                mul_a   = '0;
                mul_b   = '0;
                mul_add = '0;
            end
        endcase
    end

    assign mul_full = $signed(mul_a) * $signed(mul_b);
    assign mul_next = cmd.mul_en ? (mul_full[SW-1:0] + mul_add) : mul_reg;

    // table index from z in Q32.32, clamped to [-16, 16)
    assign z_in_rng = (&mul_reg[SW-1:ZH]) | ~(|mul_reg[SW-1:ZH]);
    always_comb
    begin
        if (z_in_rng)
            idx = {~mul_reg[ZH], mul_reg[ZH-1:ZH+1-IW]};
        else if (mul_reg[SW-1])
            idx = '0;
        else
            idx = '1;
    end

    assign ram_addr = cmd.fill_we ? cmd.fill_addr : idx;

    dwsd_ram #(
        .WIDTH (dwsd_pkg::SIG_W),
        .DEPTH (dwsd_pkg::SIG_ENTRIES)
    ) u_sig_ram (
        .clk   (clk),
        .we    (cmd.fill_we),
        .addr  (ram_addr),
        .wdata (dwsd_pkg::SIG_TABLE[cmd.fill_addr]),
        .rdata (p)
    );

    // imputed count stays between the two inputs, so |c' - other| fits CW bits
    assign cp     = {{3{c_reg[CW-1]}}, c_reg} + mul_reg[XW+15:16];
    assign dd     = cp - {{3{other_reg[CW-1]}}, other_reg};
    assign dd_abs = dd[XW-1] ? (~dd + 1'b1) : dd;

    always_comb
    begin
        if (cmd.load)
            mag_next = dab_abs[CW-1:0];
        else if (cmd.mag_en)
            mag_next = dd_abs[CW-1:0];
        else
            mag_next = mag_reg;
    end

    // saturating accumulate
    assign term    = skip_reg ? '0 : {16'd0, mul_reg[SW-1:16]};
    assign sum_add = {1'b0, sum_reg} + {1'b0, term};
    assign sum_new = sum_add[SW] ? '1 : sum_add[SW-1:0];
    assign ovf_new = ovf_reg | sum_add[SW];

    always_comb
    begin
        sum_next = sum_reg;
        ovf_next = ovf_reg;
        if (cmd.acc)
        begin
            if (cmd.emit)
            begin
                sum_next = '0;
                ovf_next = 1'b0;
            end
            else
            begin
                sum_next = sum_new;
                ovf_next = ovf_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            sum_reg <= sum_next;
            ovf_reg <= ovf_next;
        end
    end

    assign stat.last = last_reg;
    assign distance  = dist_out_reg;
    assign saturated = sat_out_reg;

endmodule

FILE: src/dropout_weighted_sq_distance_core.sv
// ----------------------------------------------------------------------------
// dropout_weighted_sq_distance_core: dropout-weighted squared distance
// Accumulates squared differences of element pairs, imputing dropouts
// through a logistic table, and returns the saturated sum on the last one.
// ----------------------------------------------------------------------------
// Requests: one at a time via the shared multiply-add unit. Both dropouts:
//   accumulate; none: square, accumulate; one dropout: argument, lookup,
//   impute, difference, square, accumulate.
// Reset: table fill, request ready low meanwhile; sum and flag cleared,
//   slope = 65536, midpoint = 0. Config writes taken throughout.
module dropout_weighted_sq_distance_core (
    input  logic                         clk,
    input  logic                         rst_n,
    dwsd_in_if.sink                      item,
    dwsd_out_if.source                   result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dwsd_pkg::PADDR_W-1:0] paddr,
    input  logic [dwsd_pkg::CFG_W-1:0]   pwdata,
    output logic [dwsd_pkg::CFG_W-1:0]   prdata,
    output logic                         pready
);

    dwsd_pkg::dwsd_cmd_t        cmd;
    dwsd_pkg::dwsd_stat_t       stat;
    logic [dwsd_pkg::CFG_W-1:0] slope;
    logic [dwsd_pkg::CFG_W-1:0] midpoint;

    dwsd_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .slope    (slope),
        .midpoint (midpoint)
    );

    dwsd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .dropout_a (item.dropout_a),
        .dropout_b (item.dropout_b),
        .in_ready  (item.ready),
        .out_ready (result.ready),
        .out_valid (result.valid),
        .stat      (stat),
        .cmd       (cmd)
    );

    dwsd_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .slope        (slope),
        .midpoint     (midpoint),
        .count_a      (item.count_a),
        .dropout_a    (item.dropout_a),
        .count_b      (item.count_b),
        .dropout_b    (item.dropout_b),
        .last_element (item.last_element),
        .distance     (result.distance),
        .saturated    (result.saturated)
    );

endmodule
